// ----- design/assert_macros.svh -----
// Assertion macros for the checker file of the dimmer.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset
`define ASSERT_CLKD(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every rising edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- design/rlfd_pkg.sv -----
// Package for the RGB LED fade dimmer: command codes, widths and palette.
// No dependencies; imported by the dimmer core.
`timescale 1ns / 1ps

package rlfd_pkg;

    localparam int LEVEL_W  = 8;
    localparam int BRIGHT_W = 16;
    localparam int PAL_W    = 3;
    localparam int PROD_W   = LEVEL_W + BRIGHT_W;

    typedef logic [1:0]          t_cmd;
    typedef logic [LEVEL_W-1:0]  t_level;
    typedef logic [BRIGHT_W-1:0] t_bright;
    typedef logic [PAL_W-1:0]    t_pal_idx;
    typedef logic [PROD_W-1:0]   t_prod;

    typedef struct packed {
        t_level red;
        t_level green;
        t_level blue;
    } t_rgb;

    localparam t_cmd CMD_SET_COLOUR = 2'd0;
    localparam t_cmd CMD_STEP       = 2'd1;
    localparam t_cmd CMD_CYCLE      = 2'd2;
    localparam t_cmd CMD_TICK       = 2'd3;

    localparam t_pal_idx PAL_LAST = 3'd6;

    // Fixed colour palette; any stray index reads as white
    function automatic t_rgb palette_colour(input t_pal_idx idx);
        t_rgb c;
        unique case (idx)
            3'd0:    c = '{red: 8'd255, green: 8'd255, blue: 8'd255};
            3'd1:    c = '{red: 8'd255, green: 8'd0,   blue: 8'd0};
            3'd2:    c = '{red: 8'd0,   green: 8'd170, blue: 8'd255};
            3'd3:    c = '{red: 8'd80,  green: 8'd220, blue: 8'd0};
            3'd4:    c = '{red: 8'd180, green: 8'd0,   blue: 8'd255};
            3'd5:    c = '{red: 8'd0,   green: 8'd0,   blue: 8'd255};
            3'd6:    c = '{red: 8'd255, green: 8'd100, blue: 8'd4};
            default: c = '{red: 8'd255, green: 8'd255, blue: 8'd255};
        endcase
        return c;
    endfunction

endpackage

// ----- design/rgb_led_fade_dimmer_core.sv -----
// RGB LED fade dimmer: command decode, colour fade, brightness and PWM scaling.
// Depends on rlfd_pkg.
`timescale 1ns / 1ps

// Usage
//   Input channel: i_valid / o_stall carry one command beat (i_cmd, colour
//   levels, signed brightness step). A beat is taken when i_valid is high
//   and o_stall is low.
//   Output channel: o_valid / i_stall carry one result beat per command:
//   three PWM compare values (level * brightness / 255), step_accepted and
//   fading. A beat is delivered when o_valid is high and i_stall is low.
//   Config: i_cfg_wr_en with i_cfg_wr_data writes the brightness ceiling;
//   write it only while no command is in flight.
//   Path: input register, state update register, channel multiply register,
//   then divide by 255 into the output register.
//   Throughput: one command per cycle while the output is not stalled; the
//   state update stage is the only loop.
//   Stall: a held output stops the pipe stage by stage; bubbles are squeezed
//   out first, so o_stall rises only when all four stages hold a beat.
//   Reset (synchronous, i_rst_n low): pipe empties, levels and target go to
//   zero, no fade, palette points at white, brightness at its minimum and the
//   ceiling at 1000.
module rgb_led_fade_dimmer_core
    import rlfd_pkg::*;
#(
    parameter int FADE_STEPS     = 255,
    parameter int MIN_BRIGHTNESS = 20
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [15:0]        i_cfg_wr_data,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_cmd,
    input  logic [7:0]         i_red_in,
    input  logic [7:0]         i_green_in,
    input  logic [7:0]         i_blue_in,
    input  logic signed [15:0] i_brightness_step,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [15:0]        o_pwm_red,
    output logic [15:0]        o_pwm_green,
    output logic [15:0]        o_pwm_blue,
    output logic               o_step_accepted,
    output logic               o_fading
);

    localparam logic [7:0]          FADE_LEN   = 8'(FADE_STEPS);
    localparam logic [BRIGHT_W:0]   MIN_WIDE   = (BRIGHT_W+1)'(MIN_BRIGHTNESS);
    localparam t_bright             BRIGHT_RST = BRIGHT_W'(MIN_BRIGHTNESS);
    localparam t_bright             CEIL_RST   = 16'd1000;
    localparam int                  QW         = PROD_W + 25;

    // Move a level one unit toward its target
    function automatic t_level approach(input t_level cur, input t_level tgt);
        t_level r;
        if (tgt > cur) begin
            r = cur + 8'd1;
        end else if (tgt < cur) begin
            r = cur - 8'd1;
        end else begin
            r = cur;
        end
        return r;
    endfunction

    // Floor divide by 255 via reciprocal 2^24+2^16+2^8+2 over 2^32, exact below 2^24
    function automatic t_bright div255(input t_prod x);
        logic [QW-1:0] s;
        s = {1'b0, x, 24'd0} + {9'd0, x, 16'd0} + {17'd0, x, 8'd0} + {24'd0, x, 1'b0};
        return s[47:32];
    endfunction

    // Handshake advance chain
    logic r_in_valid, r_s1_valid, r_s2_valid, r_out_valid;
    logic w_adv0, w_adv1, w_adv2, w_adv3;

    assign w_adv3  = !r_out_valid || !i_stall;
    assign w_adv2  = !r_s2_valid || w_adv3;
    assign w_adv1  = !r_s1_valid || w_adv2;
    assign w_adv0  = !r_in_valid || w_adv1;
    assign o_stall = !w_adv0;
    assign o_valid = r_out_valid;

    // Input register
    t_cmd           r_in_cmd;
    t_rgb           r_in_rgb;
    logic [15:0]    r_in_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_adv0) begin
            r_in_valid <= i_valid;
        end
        if (w_adv0 && i_valid) begin
            r_in_cmd  <= i_cmd;
            r_in_rgb  <= '{red: i_red_in, green: i_green_in, blue: i_blue_in};
            r_in_step <= i_brightness_step;
        end
    end

    // Ceiling register
    t_bright r_ceiling;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ceiling <= CEIL_RST;
        end else if (i_cfg_wr_en) begin
            r_ceiling <= i_cfg_wr_data;
        end
    end

    // Dimmer state
    t_rgb       r_level, n_level;
    t_rgb       r_target, n_target;
    logic [7:0] r_ticks, n_ticks;
    t_pal_idx   r_pal, n_pal;
    t_bright    r_bright, n_bright;
    logic       n_acc;
    logic       r_s1_acc, r_s1_fade;

    logic [BRIGHT_W+1:0] w_sum;
    logic                w_step_ok;
    t_pal_idx            w_idx;
    logic [7:0]          w_ticks_dec;

    assign w_sum = {2'b00, r_bright} + {{2{r_in_step[15]}}, r_in_step};
    assign w_step_ok = !w_sum[BRIGHT_W+1] && (w_sum[BRIGHT_W:0] >= MIN_WIDE)
                       && (w_sum[BRIGHT_W:0] <= {1'b0, r_ceiling});
    assign w_idx = (r_pal > PAL_LAST) ? '0 : r_pal;
    assign w_ticks_dec = r_ticks - 8'd1;

    // Apply one command to the state
    always_comb begin
        n_level  = r_level;
        n_target = r_target;
        n_ticks  = r_ticks;
        n_pal    = r_pal;
        n_bright = r_bright;
        n_acc    = 1'b1;
        unique case (r_in_cmd)
            CMD_SET_COLOUR: begin
                n_level = r_in_rgb;
                n_ticks = '0;
            end
            CMD_STEP: begin
                if (w_step_ok) begin
                    n_bright = w_sum[BRIGHT_W-1:0];
                end else begin
                    n_acc = 1'b0;
                end
            end
            CMD_CYCLE: begin
                n_target = palette_colour(w_idx);
                n_ticks  = FADE_LEN;
                n_pal    = (w_idx == PAL_LAST) ? '0 : w_idx + 3'd1;
            end
            CMD_TICK: begin
                if (r_ticks != '0) begin
                    n_ticks = w_ticks_dec;
                    if (w_ticks_dec == '0) begin
                        n_level = r_target;
                    end else begin
                        n_level.red   = approach(r_level.red, r_target.red);
                        n_level.green = approach(r_level.green, r_target.green);
                        n_level.blue  = approach(r_level.blue, r_target.blue);
                    end
                end
            end
            default: begin
                n_acc = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_level    <= '0;
            r_target   <= '0;
            r_ticks    <= '0;
            r_pal      <= '0;
            r_bright   <= BRIGHT_RST;
            r_s1_acc   <= 1'b1;
            r_s1_fade  <= 1'b0;
        end else if (w_adv1) begin
            r_s1_valid <= r_in_valid;
            if (r_in_valid) begin
                r_level   <= n_level;
                r_target  <= n_target;
                r_ticks   <= n_ticks;
                r_pal     <= n_pal;
                r_bright  <= n_bright;
                r_s1_acc  <= n_acc;
                r_s1_fade <= (n_ticks != '0);
            end
        end
    end

    // Multiply each level by the brightness
    t_prod r_prod_red, r_prod_green, r_prod_blue;
    logic  r_s2_acc, r_s2_fade;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (w_adv2) begin
            r_s2_valid <= r_s1_valid;
        end
        if (w_adv2 && r_s1_valid) begin
            r_prod_red   <= PROD_W'(r_level.red) * PROD_W'(r_bright);
            r_prod_green <= PROD_W'(r_level.green) * PROD_W'(r_bright);
            r_prod_blue  <= PROD_W'(r_level.blue) * PROD_W'(r_bright);
            r_s2_acc     <= r_s1_acc;
            r_s2_fade    <= r_s1_fade;
        end
    end

    // Divide by 255 into the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv3) begin
            r_out_valid <= r_s2_valid;
        end
        if (w_adv3 && r_s2_valid) begin
            o_pwm_red       <= div255(r_prod_red);
            o_pwm_green     <= div255(r_prod_green);
            o_pwm_blue      <= div255(r_prod_blue);
            o_step_accepted <= r_s2_acc;
            o_fading        <= r_s2_fade;
        end
    end

endmodule

// ----- design/rlfd_checker.sv -----
// Port-level checks for the RGB LED fade dimmer, bound to the core.
// Depends on assert_macros.svh and rgb_led_fade_dimmer_core.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rlfd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [15:0] o_pwm_red,
    input logic [15:0] o_pwm_green,
    input logic [15:0] o_pwm_blue,
    input logic        o_step_accepted,
    input logic        o_fading
);

    // Hold a stalled result beat
    `ASSERT_CLKD(a_out_hold, i_clk, i_rst_n, o_valid && i_stall |=> o_valid, "result beat dropped while stalled")
    `ASSERT_CLKD(a_out_stable, i_clk, i_rst_n, o_valid && i_stall |=> $stable(o_pwm_red) && $stable(o_pwm_green) && $stable(o_pwm_blue) && $stable(o_step_accepted) && $stable(o_fading), "stalled result beat changed")

    // Back-pressure only when the output holds a beat and the receiver stalls
    `ASSERT_CLKD(a_stall_full, i_clk, i_rst_n, o_stall |-> o_valid && i_stall, "input stalled with room in the pipe")

    // Empty the pipe on reset
    `ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_valid && !o_stall, "pipe not empty after reset")

endmodule

bind rgb_led_fade_dimmer_core rlfd_checker u_rlfd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_stall         (o_stall),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_pwm_red       (o_pwm_red),
    .o_pwm_green     (o_pwm_green),
    .o_pwm_blue      (o_pwm_blue),
    .o_step_accepted (o_step_accepted),
    .o_fading        (o_fading)
);
